/* rtl/assert_macros.svh */
// Assertion shorthands used by the checker file.
// Every property is sampled on the rising edge of i_clk and is disabled while
// i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/ssp_pkg.sv */
`default_nettype none
package ssp_pkg;

    localparam int DIMENSIONS_DEFAULT = 2;

    localparam int POS_W    = 24;
    localparam int STRAIN_W = 29;
    localparam int RADIUS_W = 23;
    localparam int CFG_W    = 29;
    localparam int FORCE_W  = 32;
    localparam int ENERGY_W = 25;
    localparam int MAG_W    = 24;

    // Signed widths of the separation components after the image shift.
    localparam int DY_W  = 25;
    localparam int DX_W  = 30;
    localparam int DSQ_W = 59;

    localparam logic [0:0] CFG_SHEAR  = 1'b0;
    localparam logic [0:0] CFG_RADIUS = 1'b1;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd1048576;
    localparam logic [POS_W-1:0]    DSQ_MAX      = 24'd12582912;
    localparam logic [FORCE_W-1:0]  FORCE_MAX    = 32'h7FFF_FFFF;
    localparam logic [FORCE_W-1:0]  FORCE_MIN    = 32'h8000_0000;

    typedef struct packed {
        logic [POS_W-1:0] pos_a_x;
        logic [POS_W-1:0] pos_a_y;
        logic [POS_W-1:0] pos_a_z;
        logic [POS_W-1:0] pos_b_x;
        logic [POS_W-1:0] pos_b_y;
        logic [POS_W-1:0] pos_b_z;
    } t_in_word;

    typedef struct packed {
        logic [POS_W-1:0]          dist_squared;
        logic                      in_contact;
        logic [ENERGY_W-1:0]       overlap_energy;
        logic signed [FORCE_W-1:0] force_x;
        logic signed [FORCE_W-1:0] force_y;
        logic signed [FORCE_W-1:0] force_z;
    } t_out_word;

    // Per-pair data carried alongside the square root.
    typedef struct packed {
        logic [POS_W-1:0]          dsq_out;
        logic                      contact;
        logic [2:0][MAG_W-1:0]     mag;
        logic [2:0]                neg;
    } t_geom;

    // Carried alongside the overlap divider.
    typedef struct packed {
        logic [MAG_W-1:0] d_root;
        t_geom            geom;
    } t_tdiv_side;

    // Word-level results that ride along with the first force lane.
    typedef struct packed {
        logic [POS_W-1:0]    dsq_out;
        logic                contact;
        logic                dzero;
        logic [ENERGY_W-1:0] energy;
    } t_main;

    typedef struct packed {
        t_main main;
        logic  ovf;
        logic  neg;
    } t_lane_side;

endpackage
`default_nettype wire

/* rtl/ssp_divider.sv */
`default_nettype none
module ssp_divider #(
    parameter int NUM_W  = 48,
    parameter int DEN_W  = 24,
    parameter int QUO_W  = 25,
    parameter int SIDE_W = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [DEN_W-1:0]  i_den,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    output logic [QUO_W-1:0]       o_quo,
    output logic [SIDE_W-1:0]      o_side
);
    // Restoring division, one quotient bit per stage. The top bits of the
    // dividend must already be below the divisor.
    logic [DEN_W-1:0]  r_rem  [QUO_W];
    logic [QUO_W-1:0]  r_low  [QUO_W];
    logic [QUO_W-1:0]  r_quo  [QUO_W];
    logic [DEN_W-1:0]  r_den  [QUO_W];
    logic [SIDE_W-1:0] r_side [QUO_W];
    logic              r_vld  [QUO_W];

    for (genvar s = 0; s < QUO_W; s++) begin : g_step
        logic [DEN_W-1:0]  p_rem;
        logic [QUO_W-1:0]  p_low;
        logic [QUO_W-1:0]  p_quo;
        logic [DEN_W-1:0]  p_den;
        logic [SIDE_W-1:0] p_side;
        logic              p_vld;
        logic [DEN_W:0]    sh;
        logic [DEN_W+1:0]  diff;
        logic              qbit;
        logic [DEN_W-1:0]  n_rem;
        logic [QUO_W-1:0]  n_quo;

        if (s == 0) begin : g_first
            assign p_rem  = DEN_W'(i_num >> QUO_W);
            assign p_low  = i_num[QUO_W-1:0];
            assign p_quo  = '0;
            assign p_den  = i_den;
            assign p_side = i_side;
            assign p_vld  = i_valid;
        end else begin : g_next
            assign p_rem  = r_rem[s-1];
            assign p_low  = r_low[s-1];
            assign p_quo  = r_quo[s-1];
            assign p_den  = r_den[s-1];
            assign p_side = r_side[s-1];
            assign p_vld  = r_vld[s-1];
        end

        assign sh    = {p_rem, p_low[QUO_W-1-s]};
        assign diff  = {1'b0, sh} - {2'b00, p_den};
        assign qbit  = !diff[DEN_W+1];
        assign n_rem = qbit ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
        assign n_quo = {p_quo[QUO_W-2:0], qbit};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_rem;
                r_low[s]  <= p_low;
                r_quo[s]  <= n_quo;
                r_den[s]  <= p_den;
                r_side[s] <= p_side;
            end
        end
    end

    assign o_valid = r_vld[QUO_W-1];
    assign o_quo   = r_quo[QUO_W-1];
    assign o_side  = r_side[QUO_W-1];
endmodule
`default_nettype wire

/* rtl/ssp_isqrt.sv */
`default_nettype none
module ssp_isqrt #(
    parameter int IN_W   = 48,
    parameter int SIDE_W = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [IN_W-1:0]   i_val,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    output logic [IN_W/2-1:0]      o_root,
    output logic [SIDE_W-1:0]      o_side
);
    localparam int OUT_W = IN_W / 2;
    localparam int REM_W = OUT_W + 2;

    // Digit-by-digit square root, one root bit per stage.
    logic [REM_W-1:0]  r_rem  [OUT_W];
    logic [OUT_W-1:0]  r_root [OUT_W];
    logic [IN_W-1:0]   r_val  [OUT_W];
    logic [SIDE_W-1:0] r_side [OUT_W];
    logic              r_vld  [OUT_W];

    for (genvar s = 0; s < OUT_W; s++) begin : g_step
        logic [REM_W-1:0]  p_rem;
        logic [OUT_W-1:0]  p_root;
        logic [IN_W-1:0]   p_val;
        logic [SIDE_W-1:0] p_side;
        logic              p_vld;
        logic [REM_W-1:0]  sh;
        logic [REM_W-1:0]  trial;
        logic [REM_W:0]    diff;
        logic              ge;
        logic [REM_W-1:0]  n_rem;
        logic [OUT_W-1:0]  n_root;

        if (s == 0) begin : g_first
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_val  = i_val;
            assign p_side = i_side;
            assign p_vld  = i_valid;
        end else begin : g_next
            assign p_rem  = r_rem[s-1];
            assign p_root = r_root[s-1];
            assign p_val  = r_val[s-1];
            assign p_side = r_side[s-1];
            assign p_vld  = r_vld[s-1];
        end

        assign sh     = {p_rem[OUT_W-1:0], p_val[IN_W-1-2*s -: 2]};
        assign trial  = {p_root, 2'b01};
        assign diff   = {1'b0, sh} - {1'b0, trial};
        assign ge     = !diff[REM_W];
        assign n_rem  = ge ? diff[REM_W-1:0] : sh;
        assign n_root = {p_root[OUT_W-2:0], ge};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_rem;
                r_root[s] <= n_root;
                r_val[s]  <= p_val;
                r_side[s] <= p_side;
            end
        end
    end

    assign o_valid = r_vld[OUT_W-1];
    assign o_root  = r_root[OUT_W-1];
    assign o_side  = r_side[OUT_W-1];
endmodule
`default_nettype wire

/* rtl/soft_sphere_pair_force_sheared_box.sv */
// Harmonic soft-sphere pair force in a unit periodic box under shear. Each
// input word carries the Q0.24 positions of two particles; each output word
// carries the minimum-image squared distance, a contact flag, the overlap
// energy and the repulsive force on particle a. The block takes one pair per
// clock cycle while the output side does not stall and hands back one result
// word per pair, in order. Its bit-serial pipelines have 24 stages of square
// root, 25 stages for the overlap fraction, 25 stages for the force quotient
// and 32 stages for the division by the radius; around them sit six geometry
// stages, one multiply stage and the output register. When a result word is
// not taken the whole pipeline holds in place and o_ready drops; nothing is
// lost or repeated.
// Configuration (shear strain at index 0, radius at index 1) must be written
// only while no pair is in flight.
`default_nettype none
module soft_sphere_pair_force_sheared_box #(
    parameter int DIMENSIONS = ssp_pkg::DIMENSIONS_DEFAULT
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire ssp_pkg::t_in_word         i_data,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output ssp_pkg::t_out_word             o_data,
    input  wire logic                      i_cfg_we,
    input  wire logic [0:0]                i_cfg_index,
    input  wire logic [ssp_pkg::CFG_W-1:0] i_cfg_data
);
    import ssp_pkg::*;

    // Any dimension other than three runs as a plane with a zero z force.
    localparam int LANES = (DIMENSIONS == 3) ? 3 : 2;

    localparam logic signed [DY_W-1:0] HALF_DY = 25'sd8388608;
    localparam logic signed [DY_W-1:0] ONE_DY  = 25'sd16777216;
    localparam logic signed [DX_W-1:0] HALF_DX = 30'sd8388608;
    localparam logic signed [DX_W-1:0] ONE_DX  = 30'sd16777216;

    // Configuration registers.
    logic signed [STRAIN_W-1:0] r_shear;
    logic [RADIUS_W-1:0]        r_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shear  <= '0;
            r_radius <= RADIUS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SHEAR: begin
                    r_shear <= i_cfg_data[STRAIN_W-1:0];
                end
                CFG_RADIUS: begin
                    r_radius <= i_cfg_data[RADIUS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // The whole pipeline advances together unless a finished word waits.
    logic en;
    logic r_out_vld;
    assign en      = !r_out_vld || i_ready;
    assign o_ready = en;

    // Stage A: raw coordinate differences, a - b.
    logic                   r_a_vld;
    logic signed [DY_W-1:0] r_a_dx, r_a_dy, r_a_dz;

    // Stage B: image shift across the y boundary, wrap of y and z.
    logic                   r_b_vld;
    logic signed [DX_W-1:0] r_b_dx;
    logic signed [DY_W-1:0] r_b_dy, r_b_dz;
    logic signed [DX_W-1:0] dx_ext, gamma_ext, n_b_dx;
    logic signed [DY_W-1:0] n_b_dy, n_b_dz;

    // Stage C: wrap of the sheared x difference.
    logic                   r_c_vld;
    logic signed [DX_W-1:0] r_c_dx;
    logic signed [DY_W-1:0] r_c_dy, r_c_dz;
    logic signed [DX_W-1:0] n_c_dx;

    // Stage D: squares and magnitudes.
    logic                          r_d_vld;
    logic signed [2*DX_W-1:0]      r_d_sqx;
    logic signed [2*DY_W-1:0]      r_d_sqy, r_d_sqz;
    logic [2*RADIUS_W-1:0]         r_d_rr;
    logic [2:0][MAG_W-1:0]         r_d_mag;
    logic [2:0]                    r_d_neg;
    logic signed [DX_W-1:0]        abs_x;
    logic signed [DY_W-1:0]        abs_y, abs_z;

    // Stage E: sum of squares.
    logic                  r_e_vld;
    logic [DSQ_W-1:0]      r_e_dsq;
    logic [2*RADIUS_W+1:0] r_e_four_rr;
    logic [2:0][MAG_W-1:0] r_e_mag;
    logic [2:0]            r_e_neg;

    // Stage F: contact test and reported squared distance.
    logic                 r_f_vld;
    logic [2*MAG_W-1:0]   r_f_dsq;
    t_geom                r_f_geom;
    logic                 n_f_contact;
    logic [POS_W-1:0]     n_f_dsq_out;

    always_comb begin
        dx_ext    = DX_W'(r_a_dx);
        gamma_ext = DX_W'(r_shear);
        if (r_a_dy > HALF_DY) begin
            n_b_dx = dx_ext - gamma_ext;
            n_b_dy = r_a_dy - ONE_DY;
        end else if (r_a_dy < -HALF_DY) begin
            n_b_dx = dx_ext + gamma_ext;
            n_b_dy = r_a_dy + ONE_DY;
        end else begin
            n_b_dx = dx_ext;
            n_b_dy = r_a_dy;
        end
        if (r_a_dz > HALF_DY) begin
            n_b_dz = r_a_dz - ONE_DY;
        end else if (r_a_dz < -HALF_DY) begin
            n_b_dz = r_a_dz + ONE_DY;
        end else begin
            n_b_dz = r_a_dz;
        end
    end

    always_comb begin
        if (r_b_dx > HALF_DX) begin
            n_c_dx = r_b_dx - ONE_DX;
        end else if (r_b_dx < -HALF_DX) begin
            n_c_dx = r_b_dx + ONE_DX;
        end else begin
            n_c_dx = r_b_dx;
        end
    end

    assign abs_x = r_c_dx[DX_W-1] ? -r_c_dx : r_c_dx;
    assign abs_y = r_c_dy[DY_W-1] ? -r_c_dy : r_c_dy;
    assign abs_z = r_c_dz[DY_W-1] ? -r_c_dz : r_c_dz;

    // The exact squared distance decides contact even when the x difference
    // stays outside the box after its single wrap.
    assign n_f_contact = r_e_dsq < DSQ_W'(r_e_four_rr);
    assign n_f_dsq_out = (r_e_dsq[DSQ_W-1:POS_W] > (DSQ_W-POS_W)'(DSQ_MAX))
                       ? DSQ_MAX : r_e_dsq[2*POS_W-1:POS_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
            r_f_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_dx <= $signed({1'b0, i_data.pos_a_x}) - $signed({1'b0, i_data.pos_b_x});
            r_a_dy <= $signed({1'b0, i_data.pos_a_y}) - $signed({1'b0, i_data.pos_b_y});
            if (DIMENSIONS == 3) begin
                r_a_dz <= $signed({1'b0, i_data.pos_a_z})
                        - $signed({1'b0, i_data.pos_b_z});
            end else begin
                r_a_dz <= '0;
            end

            r_b_dx <= n_b_dx;
            r_b_dy <= n_b_dy;
            r_b_dz <= n_b_dz;

            r_c_dx <= n_c_dx;
            r_c_dy <= r_b_dy;
            r_c_dz <= r_b_dz;

            r_d_sqx    <= r_c_dx * r_c_dx;
            r_d_sqy    <= r_c_dy * r_c_dy;
            r_d_sqz    <= r_c_dz * r_c_dz;
            r_d_rr     <= r_radius * r_radius;
            r_d_mag[0] <= abs_x[MAG_W-1:0];
            r_d_mag[1] <= abs_y[MAG_W-1:0];
            r_d_mag[2] <= abs_z[MAG_W-1:0];
            r_d_neg    <= {r_c_dz[DY_W-1], r_c_dy[DY_W-1], r_c_dx[DX_W-1]};

            r_e_dsq     <= DSQ_W'(r_d_sqx) + DSQ_W'(r_d_sqy) + DSQ_W'(r_d_sqz);
            r_e_four_rr <= {r_d_rr, 2'b00};
            r_e_mag     <= r_d_mag;
            r_e_neg     <= r_d_neg;

            r_f_dsq          <= r_e_dsq[2*MAG_W-1:0];
            r_f_geom.dsq_out <= n_f_dsq_out;
            r_f_geom.contact <= n_f_contact;
            r_f_geom.mag     <= r_e_mag;
            r_f_geom.neg     <= r_e_neg;
        end
    end

    // Distance d = floor(sqrt(D)). Only meaningful in contact, where D fits
    // in 48 bits.
    logic             sq_vld;
    logic [MAG_W-1:0] sq_root;
    logic [$bits(t_geom)-1:0] sq_side;
    t_geom            sq_geom;

    ssp_isqrt #(
        .IN_W   (2*MAG_W),
        .SIDE_W ($bits(t_geom))
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_f_vld),
        .i_val   (r_f_dsq),
        .i_side  (r_f_geom),
        .o_valid (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );
    assign sq_geom = t_geom'(sq_side);

    // Overlap fraction t = (2R - d) / 2R in Q.24.
    logic [RADIUS_W:0]     two_r;
    logic [2*MAG_W-1:0]    t_num;
    t_tdiv_side            t_side_in;
    logic                  t_vld;
    logic [ENERGY_W-1:0]   t_quo;
    logic [$bits(t_tdiv_side)-1:0] t_side_raw;
    t_tdiv_side            t_side;

    assign two_r     = {r_radius, 1'b0};
    assign t_num     = {two_r - sq_root, {MAG_W{1'b0}}};
    assign t_side_in = '{d_root: sq_root, geom: sq_geom};

    ssp_divider #(
        .NUM_W  (2*MAG_W),
        .DEN_W  (RADIUS_W+1),
        .QUO_W  (ENERGY_W),
        .SIDE_W ($bits(t_tdiv_side))
    ) u_tdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_vld),
        .i_num   (t_num),
        .i_den   (two_r),
        .i_side  (t_side_in),
        .o_valid (t_vld),
        .o_quo   (t_quo),
        .o_side  (t_side_raw)
    );
    assign t_side = t_tdiv_side'(t_side_raw);

    // Stage H: energy t*t and the numerators t*|delta|.
    logic                        r_h_vld;
    logic [2*ENERGY_W-1:0]       r_h_tt;
    logic [2:0][ENERGY_W+MAG_W-1:0] r_h_prod;
    logic [MAG_W-1:0]            r_h_dist;
    logic [POS_W-1:0]            r_h_dsq_out;
    logic                        r_h_contact;
    logic [2:0]                  r_h_neg;
    t_main                       h_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld <= 1'b0;
        end else if (en) begin
            r_h_vld <= t_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h_tt      <= t_quo * t_quo;
            r_h_prod[0] <= t_quo * t_side.geom.mag[0];
            r_h_prod[1] <= t_quo * t_side.geom.mag[1];
            r_h_prod[2] <= t_quo * t_side.geom.mag[2];
            r_h_dist    <= t_side.d_root;
            r_h_dsq_out <= t_side.geom.dsq_out;
            r_h_contact <= t_side.geom.contact;
            r_h_neg     <= t_side.geom.neg;
        end
    end

    assign h_main = '{dsq_out: r_h_dsq_out, contact: r_h_contact,
                      dzero: (r_h_dist == '0),
                      energy: r_h_tt[2*POS_W:POS_W]};

    // Force lanes: q = t*|delta| / d, then m = q * 2^24 / R with saturation.
    logic                     lane_vld  [LANES];
    t_lane_side               lane_side [LANES];
    logic signed [FORCE_W-1:0] lane_force [LANES];

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        t_lane_side            q_side_in;
        logic                  q_vld;
        logic [ENERGY_W-1:0]   q_quo;
        logic [$bits(t_lane_side)-1:0] q_side_raw;
        t_lane_side            q_side;
        t_lane_side            m_side_in;
        logic [2*MAG_W:0]      m_num;
        logic [FORCE_W-1:0]    m_quo;
        logic [$bits(t_lane_side)-1:0] m_side_raw;

        assign q_side_in = '{main: (l == 0) ? h_main : '0, ovf: 1'b0, neg: r_h_neg[l]};

        ssp_divider #(
            .NUM_W  (ENERGY_W+MAG_W),
            .DEN_W  (MAG_W),
            .QUO_W  (ENERGY_W),
            .SIDE_W ($bits(t_lane_side))
        ) u_qdiv (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (r_h_vld),
            .i_num   (r_h_prod[l]),
            .i_den   (r_h_dist),
            .i_side  (q_side_in),
            .o_valid (q_vld),
            .o_quo   (q_quo),
            .o_side  (q_side_raw)
        );
        assign q_side = t_lane_side'(q_side_raw);

        // The quotient reaches 2^32 exactly when q >= R * 2^8.
        assign m_num     = {q_quo, {MAG_W{1'b0}}};
        assign m_side_in = '{main: q_side.main,
                             ovf: (RADIUS_W'(q_quo[ENERGY_W-1:8]) >= r_radius),
                             neg: q_side.neg};

        ssp_divider #(
            .NUM_W  (2*MAG_W+1),
            .DEN_W  (RADIUS_W),
            .QUO_W  (FORCE_W),
            .SIDE_W ($bits(t_lane_side))
        ) u_mdiv (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (q_vld),
            .i_num   (m_num),
            .i_den   (r_radius),
            .i_side  (m_side_in),
            .o_valid (lane_vld[l]),
            .o_quo   (m_quo),
            .o_side  (m_side_raw)
        );
        assign lane_side[l] = t_lane_side'(m_side_raw);

        // Apply the sign last and clamp to the signed 32-bit range.
        always_comb begin
            if (!lane_side[l].neg) begin
                lane_force[l] = (lane_side[l].ovf || m_quo[FORCE_W-1])
                              ? FORCE_MAX : m_quo;
            end else if (lane_side[l].ovf || (m_quo[FORCE_W-1] && |m_quo[FORCE_W-2:0])) begin
                lane_force[l] = FORCE_MIN;
            end else begin
                lane_force[l] = -m_quo;
            end
        end
    end

    // Output register. Energy and forces are zero out of contact; forces are
    // also zero when the two particles sit on the same point.
    t_main     fin_main;
    logic      fin_push;
    t_out_word r_out;

    assign fin_main = lane_side[0].main;
    assign fin_push = fin_main.contact && !fin_main.dzero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= lane_vld[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.dist_squared   <= fin_main.dsq_out;
            r_out.in_contact     <= fin_main.contact;
            r_out.overlap_energy <= fin_main.contact ? fin_main.energy : '0;
            r_out.force_x        <= fin_push ? lane_force[0] : '0;
            r_out.force_y        <= fin_push ? lane_force[1] : '0;
            r_out.force_z        <= (fin_push && LANES == 3) ? lane_force[LANES-1] : '0;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;
endmodule
`default_nettype wire

/* rtl/ssp_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module ssp_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_valid,
    input wire logic                      o_ready,
    input wire ssp_pkg::t_in_word         i_data,
    input wire logic                      o_valid,
    input wire logic                      i_ready,
    input wire ssp_pkg::t_out_word        o_data,
    input wire logic                      i_cfg_we,
    input wire logic [0:0]                i_cfg_index,
    input wire logic [ssp_pkg::CFG_W-1:0] i_cfg_data
);
    import ssp_pkg::*;

    // A result word that is not taken keeps o_valid asserted.
    `ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid)

    // With the output register empty the pipeline never refuses a word.
    `ASSERT_IMPL(a_ready_when_empty, !o_valid, o_ready)

    // Out of contact there is no energy and no force.
    `ASSERT_IMPL(a_no_contact_zero, o_valid && !o_data.in_contact,
        o_data.overlap_energy == '0 && o_data.force_x == '0 &&
        o_data.force_y == '0 && o_data.force_z == '0)

    // The reported squared distance never exceeds its clamp.
    `ASSERT_IMPL(a_dsq_clamped, o_valid, o_data.dist_squared <= DSQ_MAX)
endmodule

bind soft_sphere_pair_force_sheared_box ssp_checker u_ssp_checker (.*);
`default_nettype wire
